[hdl/mdb_pkg.sv]
package mdb_pkg;

    // Fixed-point format of every coordinate
    localparam int FRAC_BITS = 28;
    localparam int CW        = 32;
    localparam int PROD_W    = 2 * CW;
    localparam int SUM_W     = 48;
    // Squared magnitude at or above 4.0 in the product scale
    localparam int ESC_BIT   = 2 * FRAC_BITS + 2;

    // Pixel position and palette geometry
    localparam int COL_W     = 12;
    localparam int POS_MUL_W = COL_W + 1 + CW;
    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);
    localparam int RGB_W     = 24;

    // Iteration counters
    localparam int ITER_W    = 16;
    localparam int CNT_W     = ITER_W + 1;
    localparam int PSIZE_W   = 9;

    // Stream payload widths
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 48;

    // Queue between front and back
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);

    // Configuration register indexes
    localparam int CFG_AW = 3;
    localparam logic [CFG_AW-1:0] REG_REAL_LOW     = 3'd0;
    localparam logic [CFG_AW-1:0] REG_IMAG_LOW     = 3'd1;
    localparam logic [CFG_AW-1:0] REG_STEP_REAL    = 3'd2;
    localparam logic [CFG_AW-1:0] REG_STEP_IMAG    = 3'd3;
    localparam logic [CFG_AW-1:0] REG_MAX_ITER     = 3'd4;
    localparam logic [CFG_AW-1:0] REG_PALETTE_SIZE = 3'd5;

    // Item kinds
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    typedef struct packed {
        logic signed [CW-1:0] real_low;
        logic signed [CW-1:0] imag_low;
        logic signed [CW-1:0] step_real;
        logic signed [CW-1:0] step_imag;
        logic [ITER_W-1:0]    max_iterations;
        logic [PSIZE_W-1:0]   palette_size;
    } cfg_t;

    typedef struct packed {
        logic                 op;
        logic signed [CW-1:0] c_re;
        logic signed [CW-1:0] c_im;
        logic [PAL_AW-1:0]    pal_index;
        logic [RGB_W-1:0]     rgb;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [CW-1:0] sat32(input logic [SUM_W-1:0] v);
        logic [SUM_W-CW:0] top;
        top = v[SUM_W-1:CW-1];
        if ((&top) || !(|top)) begin
            return v[CW-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(CW-1){1'b0}}};
        end else begin
            return {1'b0, {(CW-1){1'b1}}};
        end
    endfunction

endpackage

[hdl/mdb_front.sv]
module mdb_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // column, row, entry_index, entry_red, entry_green, entry_blue
    input  logic [mdb_pkg::S_DATA_W-1:0]     s_tdata,
    // op
    input  logic [0:0]                       s_tuser,
    input  mdb_pkg::cfg_t                    cfg,
    input  mdb_pkg::q_stat_t                 q_stat,
    output logic                             q_push,
    output mdb_pkg::q_entry_t                q_wdata
);

    logic                                         s1_valid_reg;
    logic                                         s1_op_reg;
    logic signed [mdb_pkg::POS_MUL_W-1:0]         prod_re_reg;
    logic signed [mdb_pkg::POS_MUL_W-1:0]         prod_im_reg;
    logic [mdb_pkg::PAL_AW-1:0]                   s1_idx_reg;
    logic [mdb_pkg::RGB_W-1:0]                    s1_rgb_reg;

    logic signed [mdb_pkg::COL_W:0]               col_s;
    logic signed [mdb_pkg::COL_W:0]               row_s;
    logic [mdb_pkg::SUM_W-1:0]                    sum_re;
    logic [mdb_pkg::SUM_W-1:0]                    sum_im;
    logic                                         s_acc;

    assign col_s    = {1'b0, s_tdata[11:0]};
    assign row_s    = {1'b0, s_tdata[23:12]};
    assign q_push   = s1_valid_reg && !q_stat.full;
    assign s_tready = !s1_valid_reg || !q_stat.full;
    assign s_acc    = s_tvalid && s_tready;

    // Hold the staged item until the queue takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    // Register the position products of an accepted item
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_op_reg   <= s_tuser[0];
            prod_re_reg <= col_s * cfg.step_real;
            prod_im_reg <= row_s * cfg.step_imag;
            s1_idx_reg  <= s_tdata[31:24];
            s1_rgb_reg  <= {s_tdata[39:32], s_tdata[47:40], s_tdata[55:48]};
        end
    end

    // Add the window origin and clamp
    assign sum_re = {{(mdb_pkg::SUM_W-mdb_pkg::CW){cfg.real_low[mdb_pkg::CW-1]}}, cfg.real_low}
                  + {{(mdb_pkg::SUM_W-mdb_pkg::POS_MUL_W){prod_re_reg[mdb_pkg::POS_MUL_W-1]}},
                     prod_re_reg};
    assign sum_im = {{(mdb_pkg::SUM_W-mdb_pkg::CW){cfg.imag_low[mdb_pkg::CW-1]}}, cfg.imag_low}
                  + {{(mdb_pkg::SUM_W-mdb_pkg::POS_MUL_W){prod_im_reg[mdb_pkg::POS_MUL_W-1]}},
                     prod_im_reg};

    always_comb begin
        q_wdata.op        = s1_op_reg;
        q_wdata.c_re      = mdb_pkg::sat32(sum_re);
        q_wdata.c_im      = mdb_pkg::sat32(sum_im);
        q_wdata.pal_index = s1_idx_reg;
        q_wdata.rgb       = s1_rgb_reg;
    end

endmodule

[hdl/mdb_queue.sv]
module mdb_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  mdb_pkg::q_entry_t   wdata,
    input  logic                pop,
    output mdb_pkg::q_entry_t   rdata,
    output mdb_pkg::q_stat_t    stat
);

    mdb_pkg::q_entry_t          mem [mdb_pkg::Q_DEPTH];
    logic [mdb_pkg::Q_AW-1:0]   wr_ptr_reg;
    logic [mdb_pkg::Q_AW-1:0]   rd_ptr_reg;
    logic [mdb_pkg::Q_AW:0]     cnt_reg;

    assign stat.full  = (cnt_reg == (mdb_pkg::Q_AW + 1)'(mdb_pkg::Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign rdata      = mem[rd_ptr_reg];

    // Store pushed items
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

[hdl/mdb_back.sv]
module mdb_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mdb_pkg::cfg_t                 cfg,
    input  mdb_pkg::q_stat_t              q_stat,
    input  mdb_pkg::q_entry_t             q_rdata,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pixel_red, pixel_green, pixel_blue, iteration_count, zero fill
    output logic [mdb_pkg::M_DATA_W-1:0]  m_tdata,
    // inside_set
    output logic [0:0]                    m_tuser
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_STEP = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;

    logic [2:0]                              state_reg;
    logic [2:0]                              state_next;

    logic signed [mdb_pkg::CW-1:0]           cre_reg;
    logic signed [mdb_pkg::CW-1:0]           cim_reg;
    logic signed [mdb_pkg::CW-1:0]           zre_reg;
    logic signed [mdb_pkg::CW-1:0]           zim_reg;
    logic signed [mdb_pkg::PROD_W-1:0]       rr_reg;
    logic signed [mdb_pkg::PROD_W-1:0]       ii_reg;
    logic signed [mdb_pkg::PROD_W-1:0]       ri_reg;
    logic [mdb_pkg::CNT_W-1:0]               cnt_reg;
    logic [mdb_pkg::PSIZE_W-1:0]             mod_reg;
    logic                                    first_reg;
    logic                                    inside_reg;

    logic [mdb_pkg::RGB_W-1:0]               pal_mem [mdb_pkg::PAL_DEPTH];
    logic [mdb_pkg::PAL_DEPTH-1:0]           pal_valid_reg;
    logic [mdb_pkg::RGB_W-1:0]               rd_data_reg;
    logic                                    rd_valid_reg;

    logic                                    m_tvalid_reg;
    logic [mdb_pkg::RGB_W-1:0]               out_rgb_reg;
    logic [mdb_pkg::CNT_W-1:0]               out_cnt_reg;
    logic                                    out_inside_reg;

    logic [mdb_pkg::PSIZE_W-1:0]             psize_eff;
    logic [mdb_pkg::PSIZE_W-1:0]             mod_inc;
    logic [mdb_pkg::PSIZE_W-1:0]             mod_next;
    logic [mdb_pkg::PROD_W-1:0]              mag;
    logic                                    escaped;
    logic                                    more;
    logic                                    over;
    logic signed [mdb_pkg::PROD_W-1:0]       dre;
    logic signed [mdb_pkg::PROD_W-1:0]       sre;
    logic signed [mdb_pkg::PROD_W-1:0]       sim;
    logic [mdb_pkg::SUM_W-1:0]               sum_re;
    logic [mdb_pkg::SUM_W-1:0]               sum_im;
    logic signed [mdb_pkg::CW-1:0]           nre;
    logic signed [mdb_pkg::CW-1:0]           nim;
    logic                                    out_free;
    logic                                    pal_wr;

    assign q_pop    = (state_reg == ST_IDLE) && !q_stat.empty;
    assign pal_wr   = q_pop && (q_rdata.op == mdb_pkg::OP_LOAD);
    assign out_free = !m_tvalid_reg || m_tready;

    // Escape test on the squares of the current z
    assign mag     = rr_reg + ii_reg;
    assign escaped = |mag[mdb_pkg::PROD_W-1:mdb_pkg::ESC_BIT];
    assign over    = cnt_reg > {1'b0, cfg.max_iterations};
    assign more    = (first_reg || !escaped) && !over;

    // Next z: rescale, add c, clamp
    assign dre    = rr_reg - ii_reg;
    assign sre    = dre >>> mdb_pkg::FRAC_BITS;
    assign sim    = ri_reg >>> (mdb_pkg::FRAC_BITS - 1);
    assign sum_re = sre[mdb_pkg::SUM_W-1:0]
                  + {{(mdb_pkg::SUM_W-mdb_pkg::CW){cre_reg[mdb_pkg::CW-1]}}, cre_reg};
    assign sum_im = sim[mdb_pkg::SUM_W-1:0]
                  + {{(mdb_pkg::SUM_W-mdb_pkg::CW){cim_reg[mdb_pkg::CW-1]}}, cim_reg};
    assign nre    = mdb_pkg::sat32(sum_re);
    assign nim    = mdb_pkg::sat32(sum_im);

    // Running count modulo the palette size
    assign psize_eff = (cfg.palette_size == '0) ? mdb_pkg::PSIZE_W'(1) : cfg.palette_size;
    assign mod_inc   = mod_reg + 1'b1;
    assign mod_next  = (mod_inc == psize_eff) ? '0 : mod_inc;

    // Sequence one pixel through square-and-add steps
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_pop && (q_rdata.op == mdb_pkg::OP_RENDER)) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_STEP;
            end
            ST_STEP: begin
                state_next = more ? ST_MUL : ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, output valid and palette valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            pal_valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == ST_EMIT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (pal_wr) begin
                pal_valid_reg[q_rdata.pal_index] <= 1'b1;
            end
        end
    end

    // Palette store: one write port, registered read at the running modulo
    always_ff @(posedge aclk) begin
        if (pal_wr) begin
            pal_mem[q_rdata.pal_index] <= q_rdata.rgb;
        end
        rd_data_reg  <= pal_mem[mod_reg[mdb_pkg::PAL_AW-1:0]];
        rd_valid_reg <= pal_valid_reg[mod_reg[mdb_pkg::PAL_AW-1:0]];
    end

    // Iteration datapath and result register
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    cre_reg   <= q_rdata.c_re;
                    cim_reg   <= q_rdata.c_im;
                    zre_reg   <= q_rdata.c_re;
                    zim_reg   <= q_rdata.c_im;
                    cnt_reg   <= '0;
                    mod_reg   <= '0;
                    first_reg <= 1'b1;
                end
            end
            ST_MUL: begin
                rr_reg <= zre_reg * zre_reg;
                ii_reg <= zim_reg * zim_reg;
                ri_reg <= zre_reg * zim_reg;
            end
            ST_STEP: begin
                if (more) begin
                    zre_reg   <= nre;
                    zim_reg   <= nim;
                    cnt_reg   <= cnt_reg + 1'b1;
                    mod_reg   <= mod_next;
                    first_reg <= 1'b0;
                end else begin
                    inside_reg <= over;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_rgb_reg    <= (inside_reg || !rd_valid_reg) ? '0 : rd_data_reg;
                    out_cnt_reg    <= cnt_reg;
                    out_inside_reg <= inside_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(mdb_pkg::M_DATA_W - mdb_pkg::RGB_W - mdb_pkg::CNT_W){1'b0}},
                       out_cnt_reg, out_rgb_reg[7:0], out_rgb_reg[15:8], out_rgb_reg[23:16]};
    assign m_tuser  = out_inside_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP) |-> (cnt_reg <= ({1'b0, cfg.max_iterations} + 1'b1)))
        else $error("iteration count beyond limit");

    a_mod_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (mod_reg < psize_eff))
        else $error("palette modulo out of range");

    a_step_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_STEP) && !first_reg) |-> (cnt_reg != '0))
        else $error("later step with zero count");

    a_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EMIT) && out_free) |=> (m_tvalid_reg && (state_reg == ST_IDLE)))
        else $error("result not presented after emit");
`endif

endmodule

[hdl/mandelbrot_escape_time_colorizer_top.sv]
// A pixel item passes the front-end product register and the queue; the back end then
// alternates multiply and step states, one square-and-add per pair, and raises m_tvalid
// from the emit state. A palette load is written when popped; the back end stays idle.
// Pixels are taken one at a time; a 4-entry queue decouples input from the loop.
// Reset (aresetn, synchronous): registers to defaults, palette entries read as zero until
// loaded (per-entry valid bits, no clearing pass), queue and output emptied.
module mandelbrot_escape_time_colorizer_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // column, row, entry_index, entry_red, entry_green, entry_blue
    input  logic [mdb_pkg::S_DATA_W-1:0]        s_tdata,
    // op
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pixel_red, pixel_green, pixel_blue, iteration_count, zero fill
    output logic [mdb_pkg::M_DATA_W-1:0]        m_tdata,
    // inside_set
    output logic [0:0]                          m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mdb_pkg::CFG_AW-1:0]          cfg_index,
    input  logic [mdb_pkg::CW-1:0]              cfg_data
);

    mdb_pkg::cfg_t       cfg_reg;
    mdb_pkg::q_stat_t    q_stat;
    mdb_pkg::q_entry_t   q_wdata;
    mdb_pkg::q_entry_t   q_rdata;
    logic                q_push;
    logic                q_pop;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.real_low       <= 32'hE000_0000;
            cfg_reg.imag_low       <= 32'hE800_0000;
            cfg_reg.step_real      <= 32'h0004_0000;
            cfg_reg.step_imag      <= 32'h0004_0000;
            cfg_reg.max_iterations <= 16'd255;
            cfg_reg.palette_size   <= 9'd256;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                mdb_pkg::REG_REAL_LOW:     cfg_reg.real_low       <= cfg_data;
                mdb_pkg::REG_IMAG_LOW:     cfg_reg.imag_low       <= cfg_data;
                mdb_pkg::REG_STEP_REAL:    cfg_reg.step_real      <= cfg_data;
                mdb_pkg::REG_STEP_IMAG:    cfg_reg.step_imag      <= cfg_data;
                mdb_pkg::REG_MAX_ITER:     cfg_reg.max_iterations <= cfg_data[mdb_pkg::ITER_W-1:0];
                mdb_pkg::REG_PALETTE_SIZE: cfg_reg.palette_size   <= cfg_data[mdb_pkg::PSIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mdb_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg_reg),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    mdb_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .stat    (q_stat)
    );

    mdb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_stat   (q_stat),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[tb/tb_mandelbrot_escape_time_colorizer_top.sv]
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time_colorizer_top;

    localparam int IDLE_LIMIT   = 1000000;
    localparam int SETTLE_WAIT  = 20;
    localparam int SQUEEZE_LEN  = 3000;
    localparam int RAND_PHASES  = 5;
    localparam int PHASE_ITEMS  = 108;

    // One input item as the block sees it
    typedef struct {
        logic        op;
        logic [11:0] column;
        logic [11:0] row;
        logic [7:0]  entry_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } cmd_t;

    // One rendered pixel
    typedef struct {
        logic [7:0]                red;
        logic [7:0]                green;
        logic [7:0]                blue;
        logic [mdb_pkg::CNT_W-1:0] count;
        logic                      in_set;
    } pixel_t;

    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [mdb_pkg::S_DATA_W-1:0] s_tdata   = '0;
    logic [0:0]                   s_tuser   = '0;
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [mdb_pkg::M_DATA_W-1:0] m_tdata;
    logic [0:0]                   m_tuser;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [mdb_pkg::CFG_AW-1:0]   cfg_index = '0;
    logic [mdb_pkg::CW-1:0]       cfg_data  = '0;

    mandelbrot_escape_time_colorizer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Shadow of the block's registers and palette
    mdb_pkg::cfg_t view_cfg;
    logic [23:0]   palette_shadow [mdb_pkg::PAL_DEPTH];

    cmd_t   cmd_q[$];
    pixel_t pixel_expect_q[$];
    cmd_t   cmd_on_bus;

    int errors        = 0;
    int n_loads       = 0;
    int n_pixels      = 0;
    int n_inside      = 0;
    int deepest_count = 0;
    int n_reg_writes  = 0;
    bit squeeze_req   = 1'b0;

    function automatic longint clamp_q428(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Apply one accepted item to the shadow state; queue the pixel it renders
    function automatic void predict_pixel(input cmd_t c);
        longint            c_re, c_im, z_re, z_im, sq_re, sq_im, sq_ri;
        longint unsigned   mag;
        int unsigned       iter, psize, pidx;
        pixel_t            px;
        if (c.op == mdb_pkg::OP_LOAD) begin
            palette_shadow[c.entry_index] = {c.red, c.green, c.blue};
            n_loads++;
            return;
        end
        c_re = clamp_q428(longint'(view_cfg.real_low)
                          + longint'({1'b0, c.column}) * longint'(view_cfg.step_real));
        c_im = clamp_q428(longint'(view_cfg.imag_low)
                          + longint'({1'b0, c.row}) * longint'(view_cfg.step_imag));
        z_re = c_re;
        z_im = c_im;
        mag  = 0;
        iter = 0;
        // Escape once |z|^2 reaches 4.0 in the product scale
        while (mag < (64'd4 << (2 * mdb_pkg::FRAC_BITS))
               && iter <= view_cfg.max_iterations) begin
            sq_re = z_re * z_re;
            sq_im = z_im * z_im;
            sq_ri = z_re * z_im;
            z_re  = clamp_q428(((sq_re - sq_im) >>> mdb_pkg::FRAC_BITS) + c_re);
            z_im  = clamp_q428((sq_ri >>> (mdb_pkg::FRAC_BITS - 1)) + c_im);
            mag   = longint'(z_re * z_re) + longint'(z_im * z_im);
            iter++;
        end
        px.in_set = (iter > view_cfg.max_iterations);
        px.count  = iter[mdb_pkg::CNT_W-1:0];
        psize     = (view_cfg.palette_size == 0) ? 1 : view_cfg.palette_size;
        pidx      = (iter % psize) % mdb_pkg::PAL_DEPTH;
        {px.red, px.green, px.blue} = px.in_set ? 24'h0 : palette_shadow[pidx];
        pixel_expect_q.push_back(px);
        n_pixels++;
        if (px.in_set)
            n_inside++;
        if (iter > deepest_count)
            deepest_count = iter;
    endfunction

    // Sender: bursts of items separated by random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_pixel(cmd_on_bus);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    cmd_on_bus = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cmd_on_bus.blue, cmd_on_bus.green, cmd_on_bus.red,
                                 cmd_on_bus.entry_index, cmd_on_bus.row, cmd_on_bus.column};
                    s_tuser  <= cmd_on_bus.op;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                                 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: ready pattern redrawn on counter wrap; one long hold on request
    int  ready_pct    = 100;
    int  pattern_cnt  = 0;
    int  hold_left    = 0;
    bit  squeeze_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (squeeze_req && !squeeze_done) begin
            squeeze_done = 1'b1;
            hold_left    = SQUEEZE_LEN;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (pattern_cnt == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    2: ready_pct = 40;
                    default: ready_pct = 10;
                endcase
            end
            pattern_cnt = (pattern_cnt + 1) % 64;
            m_tready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    // Check each pixel against the oldest prediction
    pixel_t want;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pixel_expect_q.size() == 0) begin
                $error("pixel with no prediction pending: tdata=%h tuser=%b", m_tdata, m_tuser);
                errors++;
            end else begin
                want = pixel_expect_q.pop_front();
                if (m_tdata[7:0] !== want.red) begin
                    $error("pixel_red: expected %0d, got %0d", want.red, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[15:8] !== want.green) begin
                    $error("pixel_green: expected %0d, got %0d", want.green, m_tdata[15:8]);
                    errors++;
                end
                if (m_tdata[23:16] !== want.blue) begin
                    $error("pixel_blue: expected %0d, got %0d", want.blue, m_tdata[23:16]);
                    errors++;
                end
                if (m_tdata[24 +: mdb_pkg::CNT_W] !== want.count) begin
                    $error("iteration_count: expected %0d, got %0d",
                           want.count, m_tdata[24 +: mdb_pkg::CNT_W]);
                    errors++;
                end
                if (m_tuser[0] !== want.in_set) begin
                    $error("inside_set: expected %0d, got %0d", want.in_set, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [mdb_pkg::CFG_AW-1:0] idx,
                             input logic [mdb_pkg::CW-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            mdb_pkg::REG_REAL_LOW:     view_cfg.real_low       = value;
            mdb_pkg::REG_IMAG_LOW:     view_cfg.imag_low       = value;
            mdb_pkg::REG_STEP_REAL:    view_cfg.step_real      = value;
            mdb_pkg::REG_STEP_IMAG:    view_cfg.step_imag      = value;
            mdb_pkg::REG_MAX_ITER:     view_cfg.max_iterations = value[mdb_pkg::ITER_W-1:0];
            mdb_pkg::REG_PALETTE_SIZE: view_cfg.palette_size   = value[mdb_pkg::PSIZE_W-1:0];
            default: ;
        endcase
        n_reg_writes++;
    endtask

    task automatic queue_load(input logic [7:0] idx, input logic [23:0] rgb);
        cmd_t c;
        c.op          = mdb_pkg::OP_LOAD;
        c.column      = 12'($urandom);
        c.row         = 12'($urandom);
        c.entry_index = idx;
        {c.red, c.green, c.blue} = rgb;
        cmd_q.push_back(c);
    endtask

    task automatic queue_pixel(input logic [11:0] col, input logic [11:0] row);
        cmd_t c;
        c.op          = mdb_pkg::OP_RENDER;
        c.column      = col;
        c.row         = row;
        c.entry_index = 8'($urandom);
        {c.red, c.green, c.blue} = 24'($urandom);
        cmd_q.push_back(c);
    endtask

    // Wait until every item is taken and every pixel has come back, then settle
    task automatic drain();
        while (cmd_q.size() != 0 || s_tvalid || pixel_expect_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    function automatic logic [mdb_pkg::CW-1:0] rand_step();
        int s;
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        s = $urandom_range(1 << 14, 1 << 23);
        if ($urandom_range(0, 1) == 1)
            s = -s;
        return s;
    endfunction

    // Mostly pixels near the set with small windows, some anywhere in the field
    task automatic random_phase(input int n);
        write_reg(mdb_pkg::REG_REAL_LOW, ($urandom_range(0, 4) == 0) ? $urandom
                  : int'($urandom_range(0, 805306368)) - 603979776);
        write_reg(mdb_pkg::REG_IMAG_LOW, ($urandom_range(0, 4) == 0) ? $urandom
                  : int'($urandom_range(0, 805306368)) - 402653184);
        write_reg(mdb_pkg::REG_STEP_REAL, rand_step());
        write_reg(mdb_pkg::REG_STEP_IMAG, rand_step());
        write_reg(mdb_pkg::REG_MAX_ITER, ($urandom_range(0, 5) == 0) ? $urandom_range(49, 300)
                                                                     : $urandom_range(1, 48));
        write_reg(mdb_pkg::REG_PALETTE_SIZE, ($urandom_range(0, 7) == 0)
                  ? $urandom_range(0, 511) : $urandom_range(1, 256));
        repeat (n) begin
            if ($urandom_range(0, 3) == 0)
                queue_load(8'($urandom), 24'($urandom));
            else if ($urandom_range(0, 5) == 0)
                queue_pixel(12'($urandom), 12'($urandom));
            else
                queue_pixel(12'($urandom_range(0, 47)), 12'($urandom_range(0, 47)));
        end
        drain();
    endtask

    initial begin
        view_cfg.real_low       = -32'sd536870912;
        view_cfg.imag_low       = -32'sd402653184;
        view_cfg.step_real      = 32'sd262144;
        view_cfg.step_imag      = 32'sd262144;
        view_cfg.max_iterations = 16'd255;
        view_cfg.palette_size   = 9'd256;
        foreach (palette_shadow[i])
            palette_shadow[i] = 24'h0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Defaults: end entries of the palette, pixels that escape fast
        queue_load(8'd0, 24'hFFFFFF);
        queue_load(8'd255, 24'h123456);
        queue_load(8'd1, 24'hA55A0F);
        queue_load(8'd2, 24'h00FF00);
        queue_pixel(12'd0, 12'd0);
        queue_pixel(12'd4095, 12'd4095);
        queue_pixel(12'd2048, 12'd0);
        queue_pixel(12'd4095, 12'd0);
        drain();

        // Saturated coordinates, zero iteration limit, zero palette size
        write_reg(mdb_pkg::REG_REAL_LOW, 32'h7FFF_FFFF);
        write_reg(mdb_pkg::REG_IMAG_LOW, 32'h8000_0000);
        write_reg(mdb_pkg::REG_STEP_REAL, 32'h7FFF_FFFF);
        write_reg(mdb_pkg::REG_STEP_IMAG, 32'h8000_0000);
        write_reg(mdb_pkg::REG_MAX_ITER, 32'd0);
        write_reg(mdb_pkg::REG_PALETTE_SIZE, 32'd0);
        queue_pixel(12'd0, 12'd0);
        queue_pixel(12'd4095, 12'd4095);
        queue_pixel(12'd1, 12'd1);
        drain();
        write_reg(mdb_pkg::REG_MAX_ITER, 32'd3);
        queue_pixel(12'd4095, 12'd4095);
        queue_pixel(12'd0, 12'd4095);
        drain();

        // Origin at the full iteration limit, palette size past the table
        write_reg(mdb_pkg::REG_REAL_LOW, 32'd0);
        write_reg(mdb_pkg::REG_IMAG_LOW, 32'd0);
        write_reg(mdb_pkg::REG_STEP_REAL, 32'd0);
        write_reg(mdb_pkg::REG_STEP_IMAG, 32'd0);
        write_reg(mdb_pkg::REG_MAX_ITER, 32'd65535);
        write_reg(mdb_pkg::REG_PALETTE_SIZE, 32'd511);
        queue_pixel(12'd7, 12'd9);
        drain();
        write_reg(mdb_pkg::REG_STEP_REAL, 32'h1000_0000);
        queue_pixel(12'd3, 12'd0);
        queue_pixel(12'd1, 12'd5);
        drain();

        // First random phase runs under one long output hold
        squeeze_req = 1'b1;
        repeat (RAND_PHASES)
            random_phase(PHASE_ITEMS);

        repeat (SETTLE_WAIT) @(posedge aclk);
        $display("Rendered %0d pixels (%0d inside, deepest count %0d), loaded %0d palette entries",
                 n_pixels, n_inside, deepest_count, n_loads);
        $display("Made %0d register writes across saturated, zero and full-range settings",
                 n_reg_writes);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
